@@ src/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the priority preemption stack.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int REQ_W    = 3;
    localparam int HANDLE_W = 4;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 4;
    localparam int DEPTH_W  = 4;
    localparam int REGCNT_W = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_ACTIVATE   = 3'd0,
        REQ_DEACTIVATE = 3'd1,
        REQ_ENGINE_END = 3'd2,
        REQ_PRELOAD    = 3'd3,
        REQ_PROBE      = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        STS_ACTIVATED = 4'd0,
        STS_PUSHED    = 4'd1,
        STS_DROPPED   = 4'd2,
        STS_BLOCKED   = 4'd3,
        STS_INVALID   = 4'd4,
        STS_RESTORED  = 4'd5,
        STS_IDLE      = 4'd6,
        STS_NONE      = 4'd7,
        STS_ENDED     = 4'd8,
        STS_RESET     = 4'd9,
        STS_PROBE_YES = 4'd10,
        STS_PROBE_NO  = 4'd11
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_pps_cmd;

endpackage

@@ src/pps_ram.sv @@
// ----------------------------------------------------------------------------
// pps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 8
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/pps_ctrl.sv @@
// ----------------------------------------------------------------------------
// pps_ctrl
// Request sequencer: accept, execute, hold result until taken.
// ----------------------------------------------------------------------------
module pps_ctrl
    import pps_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_pps_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/pps_dp.sv @@
// ----------------------------------------------------------------------------
// pps_dp
// Owner state, stack count, stack RAM and result registers.
// ----------------------------------------------------------------------------
module pps_dp
    import pps_pkg::*;
#(
    parameter int STACK_DEPTH = 8,
    parameter int MAX_OWNERS  = 16,
    parameter int PRIO_BITS   = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_pps_cmd            i_cmd,
    input  logic                i_cfg_wr_en,
    input  logic [REGCNT_W-1:0] i_cfg_wr_data,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [PRIO_W-1:0]   i_priority_req,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_install_request,
    output logic                o_end_notify,
    output logic [HANDLE_W-1:0] o_end_handle,
    output logic                o_restore_default,
    output logic                o_owner_valid,
    output logic [HANDLE_W-1:0] o_owner_handle,
    output logic [PRIO_W-1:0]   o_owner_priority,
    output logic [DEPTH_W-1:0]  o_stack_depth
);

    localparam int LW = (PRIO_BITS < PRIO_W) ? PRIO_BITS : PRIO_W;
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int EW = HANDLE_W + LW;
    localparam logic [CW-1:0] DEPTH_MAX = CW'(STACK_DEPTH);
    localparam logic [8:0]    OWNER_LIM = 9'(MAX_OWNERS);

    logic [REGCNT_W-1:0] r_reg_count;
    logic [REQ_W-1:0]    r_req;
    logic [HANDLE_W-1:0] r_handle;
    logic [LW-1:0]       r_prio;
    logic                r_act_valid, n_act_valid;
    logic [HANDLE_W-1:0] r_act_owner, n_act_owner;
    logic [LW-1:0]       r_act_level, n_act_level;
    logic                r_installed, n_installed;
    logic [CW-1:0]       r_count, n_count;

    logic [STATUS_W-1:0] r_status;
    logic                r_inst, r_notify, r_restore, r_ovalid;
    logic [HANDLE_W-1:0] r_ehandle, r_ohandle;
    logic [PRIO_W-1:0]   r_oprio;
    logic [DEPTH_W-1:0]  r_odepth;

    t_status             n_status;
    logic                n_inst, n_notify, n_restore, push;
    logic [HANDLE_W-1:0] n_ehandle;
    logic                req_ok, owner_ok;
    logic [EW-1:0]       rd_entry;

    function automatic logic handle_ok(input logic [HANDLE_W-1:0] h,
                                       input logic [REGCNT_W-1:0] lim);
        logic a, b;
        a = ({1'b0, h} < lim);
        b = (9'(h) < OWNER_LIM);
        return a && b;
    endfunction

    assign req_ok   = handle_ok(r_handle, r_reg_count);
    assign owner_ok = handle_ok(r_act_owner, r_reg_count);

    pps_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && push),
        .i_waddr (AW'(r_count)),
        .i_wdata ({r_act_owner, r_act_level}),
        .i_re    (i_cmd.capture),
        .i_raddr (AW'(r_count - CW'(1))),
        .o_rdata (rd_entry)
    );

    always_comb begin
        n_act_valid = r_act_valid;
        n_act_owner = r_act_owner;
        n_act_level = r_act_level;
        n_installed = r_installed;
        n_count     = r_count;
        n_status    = STS_IDLE;
        n_inst      = 1'b0;
        n_notify    = 1'b0;
        n_ehandle   = '0;
        n_restore   = 1'b0;
        push        = 1'b0;
        case (t_req'(r_req))
            REQ_ACTIVATE: begin
                if (!req_ok) begin
                    n_status = STS_INVALID;
                end else if (r_act_valid && r_prio < r_act_level) begin
                    n_status = STS_BLOCKED;
                end else begin
                    if (r_act_valid && r_prio > r_act_level) begin
                        if (r_count < DEPTH_MAX) begin
                            push     = 1'b1;
                            n_count  = r_count + CW'(1);
                            n_status = STS_PUSHED;
                        end else begin
                            n_status = STS_DROPPED;
                        end
                    end else begin
                        n_count  = '0;
                        n_status = STS_ACTIVATED;
                    end
                    n_act_valid = 1'b1;
                    n_act_owner = r_handle;
                    n_act_level = r_prio;
                    n_inst      = !r_installed;
                    n_installed = 1'b1;
                end
            end
            REQ_DEACTIVATE: begin
                if (!r_act_valid) begin
                    n_count  = '0;
                    n_status = STS_NONE;
                end else if (r_count != '0) begin
                    n_count     = r_count - CW'(1);
                    n_act_owner = rd_entry[EW-1:LW];
                    n_act_level = rd_entry[LW-1:0];
                    n_status    = STS_RESTORED;
                end else begin
                    n_notify    = owner_ok;
                    n_ehandle   = owner_ok ? r_act_owner : '0;
                    n_act_valid = 1'b0;
                    n_act_owner = '0;
                    n_act_level = '0;
                    n_count     = '0;
                    n_restore   = r_installed;
                    n_installed = 1'b0;
                    n_status    = STS_IDLE;
                end
            end
            REQ_ENGINE_END: begin
                if (r_act_valid) begin
                    n_notify    = owner_ok;
                    n_ehandle   = owner_ok ? r_act_owner : '0;
                    n_act_valid = 1'b0;
                    n_act_owner = '0;
                    n_act_level = '0;
                    n_status    = STS_ENDED;
                end else begin
                    n_status = STS_NONE;
                end
                n_installed = 1'b0;
            end
            REQ_PRELOAD: begin
                n_act_valid = 1'b0;
                n_act_owner = '0;
                n_act_level = '0;
                n_count     = '0;
                n_restore   = r_installed;
                n_installed = 1'b0;
                n_status    = STS_RESET;
            end
            REQ_PROBE: begin
                n_status = (!r_act_valid || r_prio >= r_act_level) ? STS_PROBE_YES
                                                                   : STS_PROBE_NO;
            end
            default: begin
                n_status = STS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_count <= '0;
            r_act_valid <= 1'b0;
            r_act_owner <= '0;
            r_act_level <= '0;
            r_installed <= 1'b0;
            r_count     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_reg_count <= i_cfg_wr_data;
            end
            if (i_cmd.exec) begin
                r_act_valid <= n_act_valid;
                r_act_owner <= n_act_owner;
                r_act_level <= n_act_level;
                r_installed <= n_installed;
                r_count     <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req    <= i_req_type;
            r_handle <= i_handle;
            r_prio   <= i_priority_req[LW-1:0];
        end
        if (i_cmd.exec) begin
            r_status  <= n_status;
            r_inst    <= n_inst;
            r_notify  <= n_notify;
            r_ehandle <= n_ehandle;
            r_restore <= n_restore;
            r_ovalid  <= n_act_valid;
            r_ohandle <= n_act_valid ? n_act_owner : '0;
            r_oprio   <= n_act_valid ? PRIO_W'(n_act_level) : '0;
            r_odepth  <= DEPTH_W'(n_count);
        end
    end

    assign o_status          = r_status;
    assign o_install_request = r_inst;
    assign o_end_notify      = r_notify;
    assign o_end_handle      = r_ehandle;
    assign o_restore_default = r_restore;
    assign o_owner_valid     = r_ovalid;
    assign o_owner_handle    = r_ohandle;
    assign o_owner_priority  = r_oprio;
    assign o_stack_depth     = r_odepth;

endmodule

@@ src/priority_preemption_stack.sv @@
// ----------------------------------------------------------------------------
// priority_preemption_stack
// Tracks one active owner by priority with a LIFO of preempted owners.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the input channel (i_in_valid / o_in_ready) as one beat
//   of req_type, handle and priority_req. Each request gives exactly one
//   result beat on the output channel (o_out_valid / i_out_ready).
//   After the input beat is taken, the sequencer passes through its execute
//   state and then presents the result beat.
//   The sequencer handles one request at a time (accept, stack RAM read
//   and execute, result hand-off).
//   A stalled receiver holds the result beat; no new request is taken
//   until it is delivered.
//   registered_count is written through i_cfg_wr_en / i_cfg_wr_data; the user
//   must do so only while the block is idle; the block has no such check.
//   Reset (i_rst_n low, synchronous) clears the owner, the installed flag,
//   the stack count and registered_count; stack RAM contents are not
//   cleared and are only used below the stack count.
// ----------------------------------------------------------------------------
module priority_preemption_stack
    import pps_pkg::*;
#(
    parameter int STACK_DEPTH = 8,
    parameter int MAX_OWNERS  = 16,
    parameter int PRIO_BITS   = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [REGCNT_W-1:0] i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [PRIO_W-1:0]   i_priority_req,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_install_request,
    output logic                o_end_notify,
    output logic [HANDLE_W-1:0] o_end_handle,
    output logic                o_restore_default,
    output logic                o_owner_valid,
    output logic [HANDLE_W-1:0] o_owner_handle,
    output logic [PRIO_W-1:0]   o_owner_priority,
    output logic [DEPTH_W-1:0]  o_stack_depth
);

    t_pps_cmd cmd;

    pps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    pps_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_OWNERS  (MAX_OWNERS),
        .PRIO_BITS   (PRIO_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_req_type        (i_req_type),
        .i_handle          (i_handle),
        .i_priority_req    (i_priority_req),
        .o_status          (o_status),
        .o_install_request (o_install_request),
        .o_end_notify      (o_end_notify),
        .o_end_handle      (o_end_handle),
        .o_restore_default (o_restore_default),
        .o_owner_valid     (o_owner_valid),
        .o_owner_handle    (o_owner_handle),
        .o_owner_priority  (o_owner_priority),
        .o_stack_depth     (o_stack_depth)
    );

endmodule
